// ----- design/ttg_pkg.sv -----
// Shared types and constants for the text-to-glyph grid mapper.
package ttg_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FN_TEXT  = 2'd0,
    FN_FRAME = 2'd1,
    FN_GLYPH = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic [2:0] REG_GRID_COLS  = 3'd0;
  localparam logic [2:0] REG_GRID_ROWS  = 3'd1;
  localparam logic [2:0] REG_SCROLL_ROW = 3'd2;
  localparam logic [2:0] REG_SCROLL_COL = 3'd3;
  localparam logic [2:0] REG_GLYPH_BASE = 3'd4;
  localparam logic [2:0] REG_TAB_EXTRA  = 3'd5;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_FIRST = 8'd33;
  localparam logic [7:0] CH_LAST  = 8'd126;

  // Field widths
  localparam int VAL_W   = 17;  // cell value, two's complement
  localparam int IDX_W   = 17;  // wide enough for any cell index
  localparam int EPOCH_W = 8;   // frame tag kept with every cell

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [15:0]        SAT16       = 16'hFFFF;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [VAL_W-1:0]   val;
  } cell_word_t;

endpackage

// ----- design/text_to_glyph_grid_mapper.sv -----
// Text-to-glyph grid mapper: places streamed text into a tagged cell memory.
//
// Requests arrive on in_* and are taken at one per cycle while in_ready is high. A
// text byte updates the line, column and cell cursor counters and, if it is a
// printable character inside the scrolled window, writes glyph_table[code-33] -
// glyph_base into its cell through the registered glyph lookup and the pending
// write stage. A frame start empties the grid at once by moving to a new frame tag;
// each cell word carries the tag of the frame that wrote it, and only a cell whose
// tag matches the current one reads as filled. Every 255th frame start the tags run
// out, and the block sweeps all MAX_COLS*MAX_ROWS cells (8192 by default), one cell
// a cycle, with in_ready low; the same sweep runs straight after reset. A read
// request passes through the input register, the registered memory read and the
// output register to out_*; a write still in flight to the same cell is forwarded.
// Only read requests produce results. While a result waits, one further read is
// held behind it and text, frame and glyph requests keep flowing; a second read
// then stalls the request side until the waiting result is taken. Configuration
// writes are taken at any time but should only be made while the block is quiet.
module text_to_glyph_grid_mapper
  import ttg_pkg::*;
#(
  parameter int MAX_COLS    = 128,
  parameter int MAX_ROWS    = 64,
  parameter int GLYPH_COUNT = 94
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [7:0]              in_char_code,
  input  logic [6:0]              in_entry_index,
  input  logic [15:0]             in_entry_value,
  input  logic [12:0]             in_cell_addr,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_cell_value
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int CA_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int GA_W       = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // ---------------------------------------------------------------- config
  logic [7:0]  grid_cols_r;
  logic [6:0]  grid_rows_r;
  logic [15:0] scroll_row_r;
  logic [15:0] scroll_col_r;
  logic [15:0] glyph_base_r;
  logic [3:0]  tab_extra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r  <= 8'd80;
      grid_rows_r  <= 7'd25;
      scroll_row_r <= 16'd0;
      scroll_col_r <= 16'd0;
      glyph_base_r <= 16'd0;
      tab_extra_r  <= 4'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GRID_COLS:  grid_cols_r  <= cfg_data[7:0];
        REG_GRID_ROWS:  grid_rows_r  <= cfg_data[6:0];
        REG_SCROLL_ROW: scroll_row_r <= cfg_data;
        REG_SCROLL_COL: scroll_col_r <= cfg_data;
        REG_GLYPH_BASE: glyph_base_r <= cfg_data;
        REG_TAB_EXTRA:  tab_extra_r  <= cfg_data[3:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- stage A: request register
  logic        a_vld_r;
  func_t       a_func_r;
  logic [7:0]  a_char_r;
  logic [6:0]  a_eidx_r;
  logic [15:0] a_eval_r;
  logic [12:0] a_addr_r;

  // stage B: read data, stage W: pending cell write, output register
  logic                   b_vld_r;
  logic                   b_inrange_r;
  logic [EPOCH_W-1:0]     b_epoch_r;
  logic                   b_fwd_r;
  cell_word_t             b_fwd_word_r;
  cell_word_t             rd_q;
  logic                   w_vld_r;
  logic [CA_W-1:0]        w_addr_r;
  logic [EPOCH_W-1:0]     w_epoch_r;
  logic [15:0]            g_q;
  logic                   out_vld_r;
  logic [VAL_W-1:0]       out_val_r;

  // text state
  logic [15:0]        text_line_r, text_line_nxt;
  logic [15:0]        text_col_r,  text_col_nxt;
  logic [7:0]         cursor_r,    cursor_nxt;
  logic               frame_end_r, frame_end_nxt;
  logic [EPOCH_W-1:0] epoch_r,     epoch_nxt;

  // clearing sweep
  logic               clr_busy_r, clr_busy_nxt;
  logic [CA_W-1:0]    clr_cnt_r;

  // handshake chain
  logic a_go, b_go, b_free;

  assign b_go     = b_vld_r && (!out_vld_r || out_ready);
  assign b_free   = !b_vld_r || b_go;
  assign a_go     = a_vld_r && !clr_busy_r && ((a_func_r != FN_READ) || b_free);
  assign in_ready = (!a_vld_r || a_go) && !clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_vld_r <= 1'b1;
    end else if (a_go) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func_r <= func_t'(in_func);
      a_char_r <= in_char_code;
      a_eidx_r <= in_entry_index;
      a_eval_r <= in_entry_value;
      a_addr_r <= in_cell_addr;
    end
  end

  // ---------------------------------------------------------------- placement
  logic [8:0]       cols9;
  logic [6:0]       rows;
  logic [15:0]      row_diff;
  logic             in_window;
  logic [IDX_W-1:0] place_addr;
  logic [7:0]       gslot;
  logic             printable;
  logic [8:0]       cur_sum;
  logic [4:0]       step;
  logic             glyph_rd;
  logic             glyph_we;
  logic             cell_rd;
  logic [7:0]       eidx8;
  logic [IDX_W-1:0] rd_addr17;
  logic [CA_W-1:0]  rd_addr;

  // effective grid size is capped by the storage
  assign cols9 = (9'(grid_cols_r) < 9'(MAX_COLS)) ? 9'(grid_cols_r) : 9'(MAX_COLS);
  assign rows  = (9'(grid_rows_r) < 9'(MAX_ROWS)) ? grid_rows_r : 7'(MAX_ROWS);

  assign row_diff  = text_line_r - scroll_row_r;
  assign in_window = (text_line_r >= scroll_row_r) && (row_diff < 16'(rows)) &&
                     (text_col_r >= scroll_col_r) && (9'(cursor_r) < cols9);
  assign place_addr = IDX_W'(row_diff[6:0]) * IDX_W'(cols9) + IDX_W'(cursor_r);

  assign gslot     = a_char_r - CH_FIRST;
  assign printable = (a_char_r >= CH_FIRST) && (a_char_r <= CH_LAST) &&
                     (9'(gslot) < 9'(GLYPH_COUNT));
  assign cur_sum   = 9'(cursor_r) + 9'(step);

  assign eidx8     = {1'b0, a_eidx_r};
  assign rd_addr17 = IDX_W'(a_addr_r);
  assign rd_addr   = rd_addr17[CA_W-1:0];

  always_comb begin
    text_line_nxt = text_line_r;
    text_col_nxt  = text_col_r;
    cursor_nxt    = cursor_r;
    frame_end_nxt = frame_end_r;
    epoch_nxt     = epoch_r;
    clr_busy_nxt  = clr_busy_r;
    step          = 5'd1;
    glyph_rd      = 1'b0;
    glyph_we      = 1'b0;
    cell_rd       = 1'b0;
    if (clr_busy_r && (clr_cnt_r == CA_W'(CELL_COUNT - 1))) begin
      clr_busy_nxt = 1'b0;
    end
    if (a_go) begin
      unique case (a_func_r)
        FN_TEXT: begin
          if (!frame_end_r) begin
            priority if (a_char_r == CH_NUL) begin
              frame_end_nxt = 1'b1;
            end else if (a_char_r == CH_LF) begin
              if (text_line_r != SAT16) text_line_nxt = text_line_r + 16'd1;
              text_col_nxt = 16'd0;
              cursor_nxt   = 8'd0;
            end else begin
              if (in_window) begin
                if (a_char_r == CH_TAB) begin
                  step = 5'(tab_extra_r) + 5'd1;
                end else begin
                  glyph_rd = printable && (place_addr < IDX_W'(CELL_COUNT));
                end
                // cursor stops at the right edge of the grid
                cursor_nxt = (cur_sum > cols9) ? cols9[7:0] : cur_sum[7:0];
              end
              if (text_col_r != SAT16) text_col_nxt = text_col_r + 16'd1;
            end
          end
        end
        FN_FRAME: begin
          text_line_nxt = 16'd0;
          text_col_nxt  = 16'd0;
          cursor_nxt    = 8'd0;
          frame_end_nxt = 1'b0;
          if (epoch_r == EPOCH_LAST) begin
            epoch_nxt    = EPOCH_FIRST;
            clr_busy_nxt = 1'b1;
          end else begin
            epoch_nxt = epoch_r + EPOCH_W'(1);
          end
        end
        FN_GLYPH: glyph_we = 9'(eidx8) < 9'(GLYPH_COUNT);
        FN_READ:  cell_rd  = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_line_r <= 16'd0;
      text_col_r  <= 16'd0;
      cursor_r    <= 8'd0;
      frame_end_r <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      clr_busy_r  <= 1'b1;  // sweep after reset
      clr_cnt_r   <= '0;
    end else begin
      text_line_r <= text_line_nxt;
      text_col_r  <= text_col_nxt;
      cursor_r    <= cursor_nxt;
      frame_end_r <= frame_end_nxt;
      epoch_r     <= epoch_nxt;
      clr_busy_r  <= clr_busy_nxt;
      if (clr_busy_r) clr_cnt_r <= clr_cnt_r + CA_W'(1);
      else            clr_cnt_r <= '0;
    end
  end

  // ---------------------------------------------------------------- glyph table
  logic [15:0] glyph_mem [GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (glyph_we) glyph_mem[eidx8[GA_W-1:0]] <= a_eval_r;
    if (glyph_rd) g_q <= glyph_mem[gslot[GA_W-1:0]];
  end

  // pending cell write, valid in the cycle after the glyph lookup
  always_ff @(posedge clk) begin
    if (!rst_n) w_vld_r <= 1'b0;
    else        w_vld_r <= glyph_rd;
  end

  always_ff @(posedge clk) begin
    if (glyph_rd) begin
      w_addr_r  <= place_addr[CA_W-1:0];
      w_epoch_r <= epoch_r;
    end
  end

  // ---------------------------------------------------------------- cell memory
  cell_word_t      cell_mem [CELL_COUNT];
  cell_word_t      w_word, mem_wd;
  logic            mem_we;
  logic [CA_W-1:0] mem_wa;

  assign w_word.tag = w_epoch_r;
  assign w_word.val = VAL_W'(g_q) - VAL_W'(glyph_base_r);

  assign mem_we = clr_busy_r || w_vld_r;
  assign mem_wa = clr_busy_r ? clr_cnt_r : w_addr_r;
  assign mem_wd = clr_busy_r ? cell_word_t'('0) : w_word;

  always_ff @(posedge clk) begin
    if (mem_we)  cell_mem[mem_wa] <= mem_wd;
    if (cell_rd) rd_q <= cell_mem[rd_addr];
  end

  // ---------------------------------------------------------------- stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (cell_rd) begin
      b_vld_r <= 1'b1;
    end else if (b_go) begin
      b_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_rd) begin
      b_inrange_r  <= rd_addr17 < IDX_W'(CELL_COUNT);
      b_epoch_r    <= epoch_r;
      // a write landing on the same edge is not seen by the read port
      b_fwd_r      <= w_vld_r && (w_addr_r == rd_addr);
      b_fwd_word_r <= w_word;
    end
  end

  cell_word_t b_word;
  logic       b_hit;

  assign b_word = b_fwd_r ? b_fwd_word_r : rd_q;
  assign b_hit  = b_inrange_r && (b_word.tag == b_epoch_r);

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) out_val_r <= b_hit ? b_word.val : '1;
  end

  assign out_valid      = out_vld_r;
  assign out_cell_value = signed'(out_val_r);

  // ---------------------------------------------------------------- assertions
  // a glyph write never shares the memory port with the sweep
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    w_vld_r |-> !clr_busy_r)
    else $error("cell write pending during clearing sweep");

  // tag wrap starts a sweep and restarts the tags
  a_wrap_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (a_go && (a_func_r == FN_FRAME) && (epoch_r == EPOCH_LAST))
      |=> (clr_busy_r && (epoch_r == EPOCH_FIRST)))
    else $error("tag wrap did not start a clearing sweep");

  // tag zero marks swept cells and must never be current
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("frame tag reached the swept value");

  // a read result never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !b_go)
    else $error("result register overwritten");

endmodule
